FILE: src/quad_gouraud_colour_blend_defines.svh
// Assertion macros used by the checker file.
`ifndef QUAD_GOURAUD_COLOUR_BLEND_DEFINES_SVH
`define QUAD_GOURAUD_COLOUR_BLEND_DEFINES_SVH

// Clocked assertion, switched off while reset is asserted.
`define QGCB_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, checked at every edge including reset.
`define QGCB_ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/qgcb_pkg.sv
`default_nettype none
package qgcb_pkg;
    // RGB555 word with flag bit on top
    typedef logic [15:0] t_rgb;

    localparam int CH_BITS    = 5;
    localparam int NUM_CH     = 3;
    localparam int DIV_STAGES = 5;
    localparam int FLAG_BIT   = 15;
    localparam int NUM_CROSS  = 8;

    // point triples for each cross product: area, then the three weights,
    // first for triangle (0,1,2), then for triangle (0,2,3); index 4 is the point
    localparam int CROSS_PT [NUM_CROSS][3] = '{
        '{0, 1, 2}, '{4, 1, 2}, '{0, 4, 2}, '{0, 1, 4},
        '{0, 2, 3}, '{4, 2, 3}, '{0, 4, 3}, '{0, 2, 4}
    };
endpackage
`default_nettype wire

FILE: src/qgcb_weights.sv
`default_nettype none
// Five stages: differences, products, cross products, sign fix and clamp,
// then deficit and weight sums for both triangles.
module qgcb_weights #(
    parameter int COORD_BITS = 24
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic [10*COORD_BITS-1:0]             i_coords,
    input  wire logic [63:0]                          i_colours,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic [1:0][2:0][2*COORD_BITS+3:0]         o_w,
    output logic [1:0][2*COORD_BITS+3:0]              o_def,
    output logic [1:0][2*COORD_BITS+3:0]              o_total,
    output logic [1:0]                                o_degen,
    output logic [63:0]                               o_colours
);
    localparam int C  = COORD_BITS;
    localparam int D  = C + 1;
    localparam int P  = 2 * C + 2;
    localparam int A  = 2 * C + 3;
    localparam int W  = 2 * C + 4;
    localparam int S  = 5;
    localparam int NX = qgcb_pkg::NUM_CROSS;

    logic [S-1:0] r_vld;
    logic [S:0]   w_adv;

    logic signed [D-1:0] r_d  [NX][4];
    logic signed [P-1:0] r_pr [NX][2];
    logic signed [A-1:0] r_x  [NX];
    logic [W-1:0]        r_wk [2][3];
    logic [W-1:0]        r_mk [2][3];
    logic [1:0]          r_dg4;
    logic [W-1:0]        r_w5 [2][3];
    logic [W-1:0]        r_def [2];
    logic [W-1:0]        r_tot [2];
    logic [1:0]          r_dg5;
    logic [63:0]         r_col [S];

    logic [W-1:0]        n_wk [2][3];
    logic [W-1:0]        n_mk [2][3];
    logic [1:0]          n_dg4;

    function automatic logic signed [D-1:0] sx(input logic [C-1:0] v);
        return {v[C-1], v};
    endfunction

    function automatic logic [C-1:0] cx(input logic [10*C-1:0] c, input int k);
        return c[(2*k)*C +: C];
    endfunction

    function automatic logic [C-1:0] cy(input logic [10*C-1:0] c, input int k);
        return c[(2*k+1)*C +: C];
    endfunction

    // per-stage advance chain
    assign w_adv[S] = i_ready;
    for (genvar k = 0; k < S; k++) begin : g_adv
        assign w_adv[k] = !r_vld[k] || w_adv[k+1];
    end
    assign o_ready = w_adv[0];
    assign o_valid = r_vld[S-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < S; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= (k == 0) ? i_valid : r_vld[k-1];
                end
            end
        end
    end

    // sign fix and clamp: a weight whose sign differs from the area's is clamped
    always_comb begin
        logic signed [A-1:0] c;
        logic [A-1:0]        mag;
        logic                an;
        c   = '0;
        mag = '0;
        an  = 1'b0;
        for (int t = 0; t < 2; t++) begin
            an     = r_x[4*t][A-1];
            n_dg4[t] = (r_x[4*t] == '0);
            for (int k = 0; k < 3; k++) begin
                c   = r_x[4*t+k+1];
                mag = c[A-1] ? (~c + A'(1)) : c;
                n_wk[t][k] = (c[A-1] ^ an) ? '0 : W'(mag);
                n_mk[t][k] = (c[A-1] ^ an) ? W'(mag) : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // stage 1: coordinate differences
        if (w_adv[0]) begin
            for (int j = 0; j < NX; j++) begin
                r_d[j][0] <= sx(cx(i_coords, qgcb_pkg::CROSS_PT[j][1]))
                           - sx(cx(i_coords, qgcb_pkg::CROSS_PT[j][0]));
                r_d[j][1] <= sx(cy(i_coords, qgcb_pkg::CROSS_PT[j][2]))
                           - sx(cy(i_coords, qgcb_pkg::CROSS_PT[j][0]));
                r_d[j][2] <= sx(cy(i_coords, qgcb_pkg::CROSS_PT[j][1]))
                           - sx(cy(i_coords, qgcb_pkg::CROSS_PT[j][0]));
                r_d[j][3] <= sx(cx(i_coords, qgcb_pkg::CROSS_PT[j][2]))
                           - sx(cx(i_coords, qgcb_pkg::CROSS_PT[j][0]));
            end
            r_col[0] <= i_colours;
        end
        // stage 2: products
        if (w_adv[1]) begin
            for (int j = 0; j < NX; j++) begin
                r_pr[j][0] <= P'(r_d[j][0]) * P'(r_d[j][1]);
                r_pr[j][1] <= P'(r_d[j][2]) * P'(r_d[j][3]);
            end
            r_col[1] <= r_col[0];
        end
        // stage 3: cross products
        if (w_adv[2]) begin
            for (int j = 0; j < NX; j++) begin
                r_x[j] <= A'(r_pr[j][0]) - A'(r_pr[j][1]);
            end
            r_col[2] <= r_col[1];
        end
        // stage 4: clamped weights and deficit parts
        if (w_adv[3]) begin
            r_wk     <= n_wk;
            r_mk     <= n_mk;
            r_dg4    <= n_dg4;
            r_col[3] <= r_col[2];
        end
        // stage 5: deficit and weight sum per triangle
        if (w_adv[4]) begin
            for (int t = 0; t < 2; t++) begin
                r_def[t] <= r_mk[t][0] + r_mk[t][1] + r_mk[t][2];
                r_tot[t] <= r_wk[t][0] + r_wk[t][1] + r_wk[t][2];
            end
            r_w5     <= r_wk;
            r_dg5    <= r_dg4;
            r_col[4] <= r_col[3];
        end
    end

    always_comb begin
        for (int t = 0; t < 2; t++) begin
            o_def[t]   = r_def[t];
            o_total[t] = r_tot[t];
            for (int k = 0; k < 3; k++) begin
                o_w[t][k] = r_w5[t][k];
            end
        end
    end
    assign o_degen   = r_dg5;
    assign o_colours = r_col[S-1];
endmodule
`default_nettype wire

FILE: src/qgcb_select.sv
`default_nettype none
// Three stages: triangle choice, channel-weight products, rounded numerators.
module qgcb_select #(
    parameter int COORD_BITS = 24
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_valid,
    output logic                                         o_ready,
    input  wire logic [1:0][2:0][2*COORD_BITS+3:0]       i_w,
    input  wire logic [1:0][2*COORD_BITS+3:0]            i_def,
    input  wire logic [1:0][2*COORD_BITS+3:0]            i_total,
    input  wire logic [1:0]                              i_degen,
    input  wire logic [63:0]                             i_colours,
    output logic                                         o_valid,
    input  wire logic                                    i_ready,
    output logic [2:0][2*COORD_BITS+8:0]                 o_num,
    output logic [2*COORD_BITS+3:0]                      o_total,
    output qgcb_pkg::t_rgb                               o_g0,
    output logic                                         o_fallback
);
    localparam int W  = 2 * COORD_BITS + 4;
    localparam int N  = W + qgcb_pkg::CH_BITS;
    localparam int CB = qgcb_pkg::CH_BITS;
    localparam int NC = qgcb_pkg::NUM_CH;
    localparam int S  = 3;

    logic [S-1:0] r_vld;
    logic [S:0]   w_adv;

    logic [W-1:0]   r6_w [3];
    logic [W-1:0]   r6_tot;
    qgcb_pkg::t_rgb r6_col [3];
    logic           r6_none;
    logic [N-1:0]   r7_p [NC][3];
    logic [W-1:0]   r7_tot;
    qgcb_pkg::t_rgb r7_g0;
    logic           r7_fb;
    logic [N-1:0]   r8_num [NC];
    logic [W-1:0]   r8_tot;
    qgcb_pkg::t_rgb r8_g0;
    logic           r8_fb;

    logic           w_pick1;

    assign w_adv[S] = i_ready;
    for (genvar k = 0; k < S; k++) begin : g_adv
        assign w_adv[k] = !r_vld[k] || w_adv[k+1];
    end
    assign o_ready = w_adv[0];
    assign o_valid = r_vld[S-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < S; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= (k == 0) ? i_valid : r_vld[k-1];
                end
            end
        end
    end

    // second triangle, unless degenerate, wins when the first is degenerate or on a strictly smaller deficit
    assign w_pick1 = !i_degen[1] && (i_degen[0] || (i_def[1] < i_def[0]));

    always_ff @(posedge i_clk) begin
        // stage 6: choose triangle and its corner colours
        if (w_adv[0]) begin
            for (int k = 0; k < 3; k++) begin
                r6_w[k] <= w_pick1 ? i_w[1][k] : i_w[0][k];
            end
            r6_tot    <= w_pick1 ? i_total[1] : i_total[0];
            r6_col[0] <= i_colours[15:0];
            r6_col[1] <= w_pick1 ? i_colours[47:32] : i_colours[31:16];
            r6_col[2] <= w_pick1 ? i_colours[63:48] : i_colours[47:32];
            r6_none   <= i_degen[0] && i_degen[1];
        end
        // stage 7: channel times weight
        if (w_adv[1]) begin
            for (int c = 0; c < NC; c++) begin
                for (int k = 0; k < 3; k++) begin
                    r7_p[c][k] <= N'(r6_col[k][c*CB +: CB]) * N'(r6_w[k]);
                end
            end
            r7_tot <= r6_tot;
            r7_g0  <= r6_col[0];
            r7_fb  <= r6_none || (r6_tot == '0);
        end
        // stage 8: numerator with half the divisor for rounding
        if (w_adv[2]) begin
            for (int c = 0; c < NC; c++) begin
                r8_num[c] <= r7_p[c][0] + r7_p[c][1] + r7_p[c][2]
                           + N'(r7_tot >> 1);
            end
            r8_tot <= r7_tot;
            r8_g0  <= r7_g0;
            r8_fb  <= r7_fb;
        end
    end

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            o_num[c] = r8_num[c];
        end
    end
    assign o_total    = r8_tot;
    assign o_g0       = r8_g0;
    assign o_fallback = r8_fb;
endmodule
`default_nettype wire

FILE: src/qgcb_divider.sv
`default_nettype none
// Restoring division, one quotient bit per stage, three channels side by side.
// The quotient never exceeds 31, so five stages give it exactly.
module qgcb_divider #(
    parameter int COORD_BITS = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [2:0][2*COORD_BITS+8:0]  i_num,
    input  wire logic [2*COORD_BITS+3:0]       i_total,
    input  wire qgcb_pkg::t_rgb                i_g0,
    input  wire logic                          i_fallback,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output qgcb_pkg::t_rgb                     o_colour
);
    localparam int W  = 2 * COORD_BITS + 4;
    localparam int N  = W + qgcb_pkg::CH_BITS;
    localparam int CB = qgcb_pkg::CH_BITS;
    localparam int NC = qgcb_pkg::NUM_CH;
    localparam int S  = qgcb_pkg::DIV_STAGES;

    logic [S-1:0] r_vld;
    logic [S:0]   w_adv;

    logic [N-1:0]   r_rem [S][NC];
    logic [CB-1:0]  r_q   [S][NC];
    logic [W-1:0]   r_tot [S];
    qgcb_pkg::t_rgb r_g0  [S];
    logic [S-1:0]   r_fb;

    logic [N-1:0]   n_rem [S][NC];
    logic [CB-1:0]  n_q   [S][NC];

    assign w_adv[S] = i_ready;
    for (genvar k = 0; k < S; k++) begin : g_adv
        assign w_adv[k] = !r_vld[k] || w_adv[k+1];
    end
    assign o_ready = w_adv[0];
    assign o_valid = r_vld[S-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < S; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= (k == 0) ? i_valid : r_vld[k-1];
                end
            end
        end
    end

    // one compare and subtract per channel per stage, msb first
    always_comb begin
        logic [N-1:0]  rem;
        logic [CB-1:0] q;
        logic [N-1:0]  dsh;
        rem = '0;
        q   = '0;
        dsh = '0;
        for (int s = 0; s < S; s++) begin
            dsh = N'((s == 0) ? i_total : r_tot[s-1]) << (S - 1 - s);
            for (int c = 0; c < NC; c++) begin
                rem = (s == 0) ? i_num[c] : r_rem[s-1][c];
                q   = (s == 0) ? '0 : r_q[s-1][c];
                if (rem >= dsh) begin
                    rem = rem - dsh;
                    q[S-1-s] = 1'b1;
                end
                n_rem[s][c] = rem;
                n_q[s][c]   = q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < S; s++) begin
            if (w_adv[s]) begin
                r_rem[s] <= n_rem[s];
                r_q[s]   <= n_q[s];
                r_tot[s] <= (s == 0) ? i_total : r_tot[s-1];
                r_g0[s]  <= (s == 0) ? i_g0 : r_g0[s-1];
                r_fb[s]  <= (s == 0) ? i_fallback : r_fb[s-1];
            end
        end
    end

    // degenerate or zero weight sum: corner 0 word as is
    assign o_colour = r_fb[S-1] ? r_g0[S-1]
                    : {r_g0[S-1][qgcb_pkg::FLAG_BIT],
                       r_q[S-1][2], r_q[S-1][1], r_q[S-1][0]};
endmodule
`default_nettype wire

FILE: src/quad_gouraud_colour_blend.sv
// Pipeline: 5 weight stages, 3 select/numerator stages, 5 divider stages
// (one quotient bit each). Throughput: one item per cycle unless the output
// stalls; every stage stalls on its own, so bubbles are squeezed out and
// input is taken while a result waits.
// Reset: synchronous, active low; clears only the stage valid bits.
`default_nettype none
module quad_gouraud_colour_blend #(
    parameter int COORD_BITS = 24
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
    // corner3_x, corner3_y, point_x, point_y, corner_colours, zero pad
    input  wire logic [((10*COORD_BITS+64+7)/8)*8-1:0] s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // blended_colour
    output logic [15:0]               m_axis_tdata
);
    localparam int W = 2 * COORD_BITS + 4;
    localparam int N = W + qgcb_pkg::CH_BITS;

    logic                  w1_valid, w1_ready;
    logic [1:0][2:0][W-1:0] w1_w;
    logic [1:0][W-1:0]     w1_def, w1_total;
    logic [1:0]            w1_degen;
    logic [63:0]           w1_colours;

    logic                  w2_valid, w2_ready;
    logic [2:0][N-1:0]     w2_num;
    logic [W-1:0]          w2_total;
    qgcb_pkg::t_rgb        w2_g0;
    logic                  w2_fb;

    qgcb_weights #(.COORD_BITS(COORD_BITS)) u_weights (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_coords  (s_axis_tdata[10*COORD_BITS-1:0]),
        .i_colours (s_axis_tdata[10*COORD_BITS +: 64]),
        .o_valid   (w1_valid),
        .i_ready   (w1_ready),
        .o_w       (w1_w),
        .o_def     (w1_def),
        .o_total   (w1_total),
        .o_degen   (w1_degen),
        .o_colours (w1_colours)
    );

    qgcb_select #(.COORD_BITS(COORD_BITS)) u_select (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w1_valid),
        .o_ready    (w1_ready),
        .i_w        (w1_w),
        .i_def      (w1_def),
        .i_total    (w1_total),
        .i_degen    (w1_degen),
        .i_colours  (w1_colours),
        .o_valid    (w2_valid),
        .i_ready    (w2_ready),
        .o_num      (w2_num),
        .o_total    (w2_total),
        .o_g0       (w2_g0),
        .o_fallback (w2_fb)
    );

    qgcb_divider #(.COORD_BITS(COORD_BITS)) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w2_valid),
        .o_ready    (w2_ready),
        .i_num      (w2_num),
        .i_total    (w2_total),
        .i_g0       (w2_g0),
        .i_fallback (w2_fb),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_colour   (m_axis_tdata)
    );
endmodule
`default_nettype wire

FILE: src/qgcb_checker.sv
`default_nettype none
`include "quad_gouraud_colour_blend_defines.svh"
// Port-level checks for the blend pipeline.
module qgcb_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tready,
    input wire logic        i_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [15:0] i_m_tdata
);
    // a stalled result stays put
    `QGCB_ASSERT_RST(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata), "stalled result changed")
    // an empty output stage never blocks the input
    `QGCB_ASSERT_RST(a_empty_ready, i_clk, i_rst_n, !i_m_tvalid |-> i_s_tready, "input blocked while output empty")
    // reset flushes the pipeline
    `QGCB_ASSERT_CLK(a_rst_flush, i_clk, !i_rst_n |=> !i_m_tvalid, "result valid after reset")
endmodule

bind quad_gouraud_colour_blend qgcb_checker u_qgcb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);
`default_nettype wire

FILE: verif/tb_quad_gouraud_colour_blend.sv
`timescale 1ns / 1ps
module tb_quad_gouraud_colour_blend;

    localparam int COORD_BITS = 24;
    localparam int DATA_W = ((10*COORD_BITS+64+7)/8)*8;
    localparam int LATENCY = 13;
    localparam int IDLE_LIMIT = 4000;
    localparam int N_RANDOM = 1830;

    typedef struct {
        logic signed [COORD_BITS-1:0] cx [4];
        logic signed [COORD_BITS-1:0] cy [4];
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic [63:0] colours;
    } t_quad_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // corner0_x .. corner3_y, point_x, point_y, corner_colours, zero pad
    logic [DATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // blended_colour
    logic [15:0] m_axis_tdata;

    quad_gouraud_colour_blend #(.COORD_BITS(COORD_BITS)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    logic [DATA_W-1:0] pending_items [$];
    qgcb_pkg::t_rgb expected_colours [$];
    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_fallback = 0;
    int idle_cycles = 0;
    bit stim_done = 0;
    bit drain_pause = 0;
    int hold_off = 0;
    int burst_left = 0;
    int gap_left = 0;

    function automatic logic [DATA_W-1:0] pack_item(t_quad_item it);
        logic [DATA_W-1:0] d;
        d = '0;
        for (int k = 0; k < 4; k++) begin
            d[(2*k)*COORD_BITS +: COORD_BITS] = it.cx[k];
            d[(2*k+1)*COORD_BITS +: COORD_BITS] = it.cy[k];
        end
        d[8*COORD_BITS +: COORD_BITS] = it.px;
        d[9*COORD_BITS +: COORD_BITS] = it.py;
        d[10*COORD_BITS +: 64] = it.colours;
        return d;
    endfunction

    // doubled signed area of (a,b,q), exact at 64 bits
    function automatic longint tri_area2(longint ax, longint ay, longint bx, longint by,
                                         longint qx, longint qy);
        return (bx - ax) * (qy - ay) - (by - ay) * (qx - ax);
    endfunction

    // Gouraud colour of the point: best triangle, clamped weights, rounded division
    function automatic qgcb_pkg::t_rgb blend_colour(logic [DATA_W-1:0] d);
        longint xs [5];
        longint ys [5];
        qgcb_pkg::t_rgb g [4];
        int corner_of [2][3];
        int best;
        logic [63:0] best_w [3];
        logic [63:0] win_sum;
        logic [63:0] best_def;
        longint area;
        longint sw [3];
        logic [63:0] w [3];
        logic [63:0] def;
        int a, b, c;
        logic [127:0] num;
        logic [127:0] q;
        qgcb_pkg::t_rgb r;
        corner_of = '{'{0, 1, 2}, '{0, 2, 3}};
        best = -1;
        win_sum = 0;
        best_def = 0;
        best_w = '{0, 0, 0};
        for (int k = 0; k < 5; k++) begin
            xs[k] = longint'($signed(d[(2*k)*COORD_BITS +: COORD_BITS]));
            ys[k] = longint'($signed(d[(2*k+1)*COORD_BITS +: COORD_BITS]));
        end
        for (int k = 0; k < 4; k++) g[k] = d[10*COORD_BITS + 16*k +: 16];
        for (int t = 0; t < 2; t++) begin
            a = corner_of[t][0]; b = corner_of[t][1]; c = corner_of[t][2];
            area = tri_area2(xs[a], ys[a], xs[b], ys[b], xs[c], ys[c]);
            if (area != 0) begin
                sw[0] = tri_area2(xs[4], ys[4], xs[b], ys[b], xs[c], ys[c]);
                sw[1] = tri_area2(xs[a], ys[a], xs[4], ys[4], xs[c], ys[c]);
                sw[2] = tri_area2(xs[a], ys[a], xs[b], ys[b], xs[4], ys[4]);
                def = 0;
                for (int k = 0; k < 3; k++) begin
                    if (area < 0) sw[k] = -sw[k];
                    if (sw[k] < 0) begin
                        def += 64'(-sw[k]);
                        w[k] = 0;
                    end else begin
                        w[k] = 64'(sw[k]);
                    end
                end
                if (best < 0 || def < best_def) begin
                    best = t;
                    best_def = def;
                    win_sum = w[0] + w[1] + w[2];
                    best_w = w;
                end
            end
        end
        if (best < 0 || win_sum == 0) return g[0];
        r = g[0] & 16'h8000;
        for (int ch = 0; ch < qgcb_pkg::NUM_CH; ch++) begin
            num = 0;
            for (int k = 0; k < 3; k++)
                num += 128'(best_w[k])
                       * 128'(g[corner_of[best][k]][ch*qgcb_pkg::CH_BITS +: qgcb_pkg::CH_BITS]);
            num += 128'(win_sum / 2);
            q = num / 128'(win_sum);
            if (q > 31) q = 31;
            r[ch*qgcb_pkg::CH_BITS +: qgcb_pkg::CH_BITS] = q[4:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(qgcb_pkg::t_rgb got, qgcb_pkg::t_rgb want);
        $display("mismatch at item %0d: colour %h, predicted %h", n_checked, got, want);
        errors++;
    endtask

    function automatic logic signed [COORD_BITS-1:0] rand_coord(int mode);
        case (mode)
            0: return COORD_BITS'($urandom);
            1: return COORD_BITS'($urandom_range(0, 200) - 100);
            2: return COORD_BITS'($urandom_range(0, 8000) - 4000);
            default: return ($urandom & 1) ? {1'b0, {(COORD_BITS-1){1'b1}}}
                                           : {1'b1, {(COORD_BITS-1){1'b0}}};
        endcase
    endfunction

    task automatic add_item(t_quad_item it);
        pending_items.push_back(pack_item(it));
    endtask

    // Driver: bursts and gaps, plus a full drain pause when requested
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_colours.push_back(blend_colour(s_axis_tdata));
                n_sent++;
                void'(pending_items.pop_front());
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // offered item waits unchanged until taken
            end else if (drain_pause && n_sent == 900 && expected_colours.size() != 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end
                burst_left--;
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pending_items[0];
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern with one long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (n_sent > 300 && n_sent < 320 && hold_off == 0) hold_off = 200;
            if (hold_off > 1) begin
                hold_off--;
                m_axis_tready <= 1'b0;
            end else begin
                case ((n_checked / 128) % 3)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 1) == 0);
                endcase
            end
        end
    end

    // Monitor: check each result against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_colours.size() == 0) begin
                    $display("unexpected colour %h", m_axis_tdata);
                    errors++;
                end else begin
                    if (m_axis_tdata !== expected_colours[0])
                        report_mismatch(m_axis_tdata, expected_colours[0]);
                    void'(expected_colours.pop_front());
                end
                n_checked++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        t_quad_item it;
        int mode;
        int shape;
        // directed: 64-by-64 square, degenerate quads, extremes, outside points
        it.colours = 64'h7FFF_03E0_801F_7C00;
        it.cx = '{0, 64, 64, 0};
        it.cy = '{0, 0, 64, 64};
        for (int k = 0; k < 4; k++) begin
            it.px = it.cx[k]; it.py = it.cy[k]; add_item(it);
        end
        it.px = 32; it.py = 32; add_item(it);
        it.px = 10; it.py = 50; add_item(it);
        it.px = -500; it.py = 900; add_item(it);
        it.px = 1000; it.py = -1000; add_item(it);
        // clockwise winding
        it.cx = '{0, 0, 64, 64}; it.cy = '{0, 64, 64, 0};
        it.px = 20; it.py = 7; add_item(it);
        // both triangles degenerate: all collinear, all equal
        it.cx = '{0, 1, 2, 3}; it.cy = '{0, 1, 2, 3};
        it.px = 5; it.py = 9; add_item(it);
        it.cx = '{7, 7, 7, 7}; it.cy = '{7, 7, 7, 7}; add_item(it);
        // first triangle degenerate only
        it.cx = '{0, 5, 10, 0}; it.cy = '{0, 0, 0, 10};
        it.px = 3; it.py = 3; add_item(it);
        // extreme coordinates
        for (int k = 0; k < 4; k++) begin
            it.cx[k] = (k == 1 || k == 2) ? 24'sh7FFFFF : 24'sh800000;
            it.cy[k] = (k >= 2) ? 24'sh7FFFFF : 24'sh800000;
        end
        it.colours = '1;
        it.px = 24'sh7FFFFF; it.py = 24'sh800000; add_item(it);
        it.px = 0; it.py = 0; add_item(it);
        it.px = 24'sh800000; it.py = 24'sh7FFFFF; it.colours = '0; add_item(it);
        it.colours = 64'h8000_FFFF_0000_7FFF; add_item(it);
        // random: mostly small quads, some degenerate, plus noise
        for (int n = 0; n < N_RANDOM; n++) begin
            shape = $urandom_range(0, 9);
            mode = (shape < 6) ? $urandom_range(1, 2) : (shape < 9 ? 0 : 3);
            it.colours = {$urandom, $urandom};
            for (int k = 0; k < 4; k++) begin
                it.cx[k] = rand_coord(mode);
                it.cy[k] = rand_coord(mode);
            end
            if (shape == 5) it.cy = '{it.cy[0], it.cy[0], it.cy[0], it.cy[0]};
            if (shape == 4) it.cx[3] = it.cx[0];
            if ($urandom_range(0, 3) == 0) begin
                it.px = rand_coord($urandom_range(0, 3));
                it.py = rand_coord($urandom_range(0, 3));
            end else begin
                it.px = COORD_BITS'((it.cx[0] + it.cx[1] + it.cx[2] + it.cx[3]) / 4
                        + $signed($urandom_range(0, 20)) - 10);
                it.py = COORD_BITS'((it.cy[0] + it.cy[1] + it.cy[2] + it.cy[3]) / 4
                        + $signed($urandom_range(0, 20)) - 10);
            end
            add_item(it);
        end
        drain_pause = 1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_items.size() == 0 && !s_axis_tvalid);
        wait (expected_colours.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("%0d quads sent, %0d colours checked, with bursts, stalls and a long hold-off",
                 n_sent, n_checked);
        if (errors == 0 && expected_colours.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
